[src/sos_pkg.sv]
// shared types, opcodes and status codes for the set of stacks block
// no dependencies

package sos_pkg;

    localparam int DEF_NUM_STACKS  = 4;
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_DATA_WIDTH  = 32;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int SEL_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CUR_W    = 2;

    localparam int IN_BITS   = OPCODE_W + VALUE_W + SEL_W;
    localparam int OUT_BITS  = STATUS_W + VALUE_W + CUR_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_AT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    // command broadcast along the row of cells
    typedef struct packed {
        logic                fire;
        logic [OPCODE_W-1:0] op;
        logic [SEL_W-1:0]    sel;
        logic                at_ok;
    } sos_cmd_t;

endpackage

[src/sos_ram.sv]
// generic simple dual-port ram with registered read
// no dependencies

module sos_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/sos_cell.sv]
// one sub-stack: fill count, entry ram and overflow hand-off to its neighbours
// depends on sos_pkg and sos_ram

module sos_cell
    import sos_pkg::*;
#(
    parameter  int INDEX       = 0,
    parameter  int NUM_STACKS  = DEF_NUM_STACKS,
    parameter  int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter  int DATA_WIDTH  = DEF_DATA_WIDTH,
    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sos_cmd_t              cmd,
    input  logic [SW-1:0]         cur,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic                  lower_full,
    input  logic                  upper_empty,
    output logic                  full,
    output logic                  empty,
    output logic [DATA_WIDTH-1:0] rd_data
);

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNW = $clog2(STACK_DEPTH + 1);
    localparam int CW  = SW + 1;

    localparam logic [CW-1:0]  IDX    = CW'(INDEX);
    localparam logic [CW-1:0]  IDX_M1 = CW'(INDEX - 1);
    localparam logic [CW-1:0]  IDX_P1 = CW'(INDEX + 1);
    localparam logic [CNW-1:0] DEPTH_C = CNW'(STACK_DEPTH);

    logic [CNW-1:0] count_reg;
    logic [CNW-1:0] count_next;
    logic [CW-1:0]  cur_ext;
    logic           is_cur;
    logic           is_above;
    logic           is_below;
    logic           sel_hit;
    logic           do_push;
    logic           do_pop;

    assign full  = (count_reg == DEPTH_C);
    assign empty = (count_reg == '0);

    assign cur_ext  = CW'(cur);
    assign is_cur   = (cur_ext == IDX);
    assign is_above = (INDEX > 0) && (cur_ext == IDX_M1);
    assign is_below = (cur_ext == IDX_P1);
    assign sel_hit  = (INDEX < 4) && (cmd.sel == SEL_W'(INDEX));

    // a push overflows upward from a full lower cell, a pop falls down from an empty upper one
    assign do_push = cmd.fire && (cmd.op == OP_PUSH) && !full
                     && (is_cur || (is_above && lower_full));
    assign do_pop  = cmd.fire && !empty
                     && (((cmd.op == OP_POP) && (is_cur || (is_below && upper_empty)))
                         || ((cmd.op == OP_POP_AT) && cmd.at_ok && sel_hit));

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    sos_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (AW'(count_reg)),
        .wr_data (value),
        .rd_en   (do_pop),
        .rd_addr (AW'(count_reg - 1'b1)),
        .rd_data (rd_data)
    );

endmodule

[src/set_of_stacks_top.sv]
// top level of the set of stacks block: command decode, row of cells, output register
// depends on sos_pkg, sos_cell and sos_ram
//
// usage
//   s_axis carries one operation per item: tdata holds opcode, push_value and
//   stack_select from the lowest bit up. m_axis returns one result per item:
//   tdata holds status, pop_value and current_stack from the lowest bit up.
//   each sub-stack is one cell with its own fill count and entry ram; a push
//   that finds the current cell full spills into the cell above, a pop that
//   finds it empty falls to the cell below.
//   path: decode results and the ram read are registered when an item is
//   accepted, then its result is registered in the output register.
//   throughput: one item per cycle while m_axis_tready stays high, set by
//   the single ram access per cell and the fill counts updated at acceptance.
//   reset: all fill counts and the current index clear at once, no clearing
//   pass; entry rams are not cleared and only written entries are ever read.
//   stall: while m_axis_tready is low the result holds in the output
//   register, one more item may complete its decode behind it, then
//   s_axis_tready falls until the output register drains.

module set_of_stacks_top
    import sos_pkg::*;
#(
    parameter int NUM_STACKS  = DEF_NUM_STACKS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // opcode, push_value, stack_select
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // status, pop_value, current_stack
);

    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CW = SW + 1;
    localparam logic [SW-1:0] LAST = SW'(NUM_STACKS - 1);

    logic [OPCODE_W-1:0]   in_opcode;
    logic signed [VALUE_W-1:0] in_value;
    logic [SEL_W-1:0]      in_sel;
    logic [DATA_WIDTH-1:0] cell_value;

    logic                  accept;
    logic                  out_free;

    logic [SW-1:0]         cur_reg;
    logic [SW-1:0]         cur_next;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [STATUS_W-1:0]   s1_status_reg;
    logic [SW-1:0]         s1_cur_reg;
    logic                  s1_pop_reg;
    logic [SW-1:0]         s1_cell_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [CUR_W-1:0]      out_cur_reg;

    logic [STATUS_W-1:0]   dec_status;
    logic                  dec_pop;
    logic [SW-1:0]         dec_cell;
    logic [SW-1:0]         nxt;
    logic [SW-1:0]         prv;
    logic [SW-1:0]         sel_idx;
    logic                  at_ok;

    sos_cmd_t              cmd;
    logic [NUM_STACKS-1:0] full;
    logic [NUM_STACKS-1:0] empty;
    logic [DATA_WIDTH-1:0] rd_data [NUM_STACKS];
    logic signed [DATA_WIDTH-1:0] sel_data;

    assign in_opcode  = s_axis_tdata[OPCODE_W-1:0];
    assign in_value   = s_axis_tdata[OPCODE_W+VALUE_W-1:OPCODE_W];
    assign in_sel     = s_axis_tdata[OPCODE_W+VALUE_W+SEL_W-1:OPCODE_W+VALUE_W];
    assign cell_value = DATA_WIDTH'(in_value);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign nxt     = cur_reg + 1'b1;
    assign prv     = cur_reg - 1'b1;
    assign sel_idx = SW'(in_sel);
    assign at_ok   = ((CW + SEL_W)'(in_sel) <= (CW + SEL_W)'(cur_reg));

    always_comb
    begin
        dec_status = ST_OK;
        dec_pop    = 1'b0;
        dec_cell   = cur_reg;
        cur_next   = cur_reg;
        unique case (in_opcode)
            OP_PUSH:
            begin
                if (full[cur_reg])
                begin
                    if (cur_reg == LAST)
                    begin
                        dec_status = ST_FULL;
                    end
                    else
                    begin
                        cur_next = nxt;
                        if (full[nxt])
                        begin
                            dec_status = ST_FULL;
                        end
                    end
                end
            end
            OP_POP:
            begin
                if (!empty[cur_reg])
                begin
                    dec_pop = 1'b1;
                end
                else if (cur_reg == '0)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    cur_next = prv;
                    dec_cell = prv;
                    if (empty[prv])
                    begin
                        dec_status = ST_EMPTY;
                    end
                    else
                    begin
                        dec_pop = 1'b1;
                    end
                end
            end
            OP_POP_AT:
            begin
                dec_cell = sel_idx;
                if (!at_ok)
                begin
                    dec_status = ST_INVALID;
                end
                else if (empty[sel_idx])
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_pop = 1'b1;
                end
            end
            default:
            begin
                dec_status = ST_INVALID;
            end
        endcase
    end

    assign cmd.fire  = accept;
    assign cmd.op    = in_opcode;
    assign cmd.sel   = in_sel;
    assign cmd.at_ok = at_ok;

    for (genvar i = 0; i < NUM_STACKS; i++)
    begin : g_cell
        logic lower_full;
        logic upper_empty;

        if (i == 0)
        begin : g_bottom
            assign lower_full = 1'b0;
        end
        else
        begin : g_lower
            assign lower_full = full[i-1];
        end

        if (i == NUM_STACKS - 1)
        begin : g_top
            assign upper_empty = 1'b0;
        end
        else
        begin : g_upper
            assign upper_empty = empty[i+1];
        end

        sos_cell #(
            .INDEX       (i),
            .NUM_STACKS  (NUM_STACKS),
            .STACK_DEPTH (STACK_DEPTH),
            .DATA_WIDTH  (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .cur         (cur_reg),
            .value       (cell_value),
            .lower_full  (lower_full),
            .upper_empty (upper_empty),
            .full        (full[i]),
            .empty       (empty[i]),
            .rd_data     (rd_data[i])
        );
    end

    assign sel_data = rd_data[s1_cell_reg];

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_reg <= cur_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= dec_status;
            s1_cur_reg    <= cur_next;
            s1_pop_reg    <= dec_pop;
            s1_cell_reg   <= dec_cell;
        end
        if (out_free && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            out_cur_reg    <= CUR_W'(s1_cur_reg);
            out_value_reg  <= s1_pop_reg ? VALUE_W'(sel_data) : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_cur_reg, out_value_reg, out_status_reg});

endmodule

[dv/tb_set_of_stacks_top.sv]
// testbench for set_of_stacks_top: random and directed push, pop and pop-at items
// checked against an in-bench model of the sub-stacks, fill counts and current index
// depends on sos_pkg and set_of_stacks_top

module tb_set_of_stacks_top
    import sos_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_STACKS  = DEF_NUM_STACKS;
    localparam int STACK_DEPTH = DEF_STACK_DEPTH;
    localparam int DATA_WIDTH  = DEF_DATA_WIDTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [CUR_W-1:0]    cur;
    } stack_outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [IN_DATA_W-1:0] pending_ops[$];
    stack_outcome_t       due_outcomes[$];

    logic [DATA_WIDTH-1:0] entries [NUM_STACKS*STACK_DEPTH];
    int                    fill [NUM_STACKS];
    int                    cur_stack;

    int send_idle = 20;
    int recv_idle = 52;
    int errors = 0;
    int cycles = 0;

    set_of_stacks_top #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [IN_DATA_W-1:0] pack_item(logic [OPCODE_W-1:0] op,
                                                       logic [VALUE_W-1:0] val,
                                                       logic [SEL_W-1:0] sel);
        return IN_DATA_W'({sel, val, op});
    endfunction

    // applies one item to the model state and returns what the block must answer
    function automatic stack_outcome_t stack_outcome(logic [IN_DATA_W-1:0] word);
        logic [OPCODE_W-1:0]   op;
        logic [VALUE_W-1:0]    val;
        logic [SEL_W-1:0]      sel;
        logic [DATA_WIDTH-1:0] popped;
        logic [STATUS_W-1:0]   status;
        stack_outcome_t        res;
        op = word[OPCODE_W-1:0];
        val = word[OPCODE_W +: VALUE_W];
        sel = word[OPCODE_W+VALUE_W +: SEL_W];
        popped = '0;
        status = ST_OK;
        if (op == OP_PUSH)
        begin
            if (fill[cur_stack] < STACK_DEPTH)
            begin
                entries[cur_stack*STACK_DEPTH + fill[cur_stack]] = val[DATA_WIDTH-1:0];
                fill[cur_stack]++;
            end
            else if (cur_stack + 1 < NUM_STACKS)
            begin
                cur_stack++;
                if (fill[cur_stack] < STACK_DEPTH)
                begin
                    entries[cur_stack*STACK_DEPTH + fill[cur_stack]] = val[DATA_WIDTH-1:0];
                    fill[cur_stack]++;
                end
                else
                    status = ST_FULL;
            end
            else
                status = ST_FULL;
        end
        else if (op == OP_POP)
        begin
            if (fill[cur_stack] > 0)
            begin
                fill[cur_stack]--;
                popped = entries[cur_stack*STACK_DEPTH + fill[cur_stack]];
            end
            else if (cur_stack == 0)
                status = ST_EMPTY;
            else
            begin
                // fall to the sub-stack below, which may itself be empty after pop-at
                cur_stack--;
                if (fill[cur_stack] > 0)
                begin
                    fill[cur_stack]--;
                    popped = entries[cur_stack*STACK_DEPTH + fill[cur_stack]];
                end
                else
                    status = ST_EMPTY;
            end
        end
        else if (op == OP_POP_AT)
        begin
            if (int'(sel) > cur_stack)
                status = ST_INVALID;
            else if (fill[sel] == 0)
                status = ST_EMPTY;
            else
            begin
                fill[sel]--;
                popped = entries[int'(sel)*STACK_DEPTH + fill[sel]];
            end
        end
        else
            status = ST_INVALID;
        res.status = status;
        res.value = (status == ST_OK && op != OP_PUSH) ?
                    VALUE_W'($signed(popped)) : '0;
        res.cur = CUR_W'(cur_stack);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        $display("[%0t] mismatch on %s: got 'h%0h, expected 'h%0h", $realtime, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                due_outcomes.push_back(stack_outcome(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_ops.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        stack_outcome_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_outcomes.size() == 0)
                begin
                    report_mismatch("result with no item outstanding",
                                    m_tdata[STATUS_W +: VALUE_W], '0);
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== want.status)
                        report_mismatch("status", VALUE_W'(m_tdata[STATUS_W-1:0]),
                                        VALUE_W'(want.status));
                    if (m_tdata[STATUS_W +: VALUE_W] !== want.value)
                        report_mismatch("pop_value", m_tdata[STATUS_W +: VALUE_W], want.value);
                    if (m_tdata[STATUS_W+VALUE_W +: CUR_W] !== want.cur)
                        report_mismatch("current_stack",
                                        VALUE_W'(m_tdata[STATUS_W+VALUE_W +: CUR_W]),
                                        VALUE_W'(want.cur));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] val,
                          logic [SEL_W-1:0] sel);
        pending_ops.push_back(pack_item(op, val, sel));
    endtask

    task automatic add_random_ops(int n);
        int count;
        int len;
        int kind;
        int side;
        count = 0;
        while (count < n)
        begin
            kind = $urandom_range(9);
            len = (kind == 9) ? $urandom_range(1, 70) : $urandom_range(1, 40);
            if (kind == 5 || kind == 6)
                len = $urandom_range(1, 8);
            if (kind == 7)
                len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
            begin
                case (kind)
                    0, 1, 2, 9: add_op(OP_PUSH, rand_value(), SEL_W'($urandom));
                    3, 4: add_op(OP_POP, $urandom, SEL_W'($urandom));
                    5, 6: add_op(OP_POP_AT, $urandom, SEL_W'($urandom));
                    7: add_op(OPCODE_W'($urandom_range(15) == 0 ? OP_UNUSED :
                                        $urandom_range(2)), rand_value(), SEL_W'($urandom));
                    default:
                    begin
                        // empty a chosen sub-stack from the side, then pop down through it
                        side = $urandom_range(NUM_STACKS - 1);
                        for (int j = 0; j < STACK_DEPTH + 1; j++)
                            add_op(OP_POP_AT, $urandom, SEL_W'(side));
                        for (int j = 0; j < 3; j++)
                            add_op(OP_POP, $urandom, SEL_W'($urandom));
                        count += STACK_DEPTH + 3;
                        i = len;
                    end
                endcase
            end
            if (kind != 8)
                count += len;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_ops.size() != 0 || s_tvalid || due_outcomes.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        for (int s = 0; s < NUM_STACKS; s++)
            fill[s] = 0;
        cur_stack = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: value extremes, bottom empty, pop-at above current, unused opcode
        add_op(OP_POP, 32'h0, 2'd0);
        add_op(OP_POP_AT, 32'hffff_ffff, 2'd0);
        add_op(OP_POP_AT, 32'h0, 2'd1);
        add_op(OP_POP_AT, 32'h0, 2'd3);
        add_op(OP_PUSH, 32'h7fff_ffff, 2'd3);
        add_op(OP_PUSH, 32'h8000_0000, 2'd0);
        add_op(OP_PUSH, 32'h0000_0000, 2'd2);
        add_op(OP_PUSH, 32'hffff_ffff, 2'd1);
        add_op(OP_PUSH, 32'haaaa_aaaa, 2'd0);
        add_op(OP_PUSH, 32'h5555_5555, 2'd3);
        add_op(OP_UNUSED, 32'hffff_ffff, 2'd3);
        add_op(OP_POP, 32'hffff_ffff, 2'd3);
        add_op(OP_POP_AT, 32'h0, 2'd0);
        add_op(OP_POP_AT, 32'h0, 2'd2);
        add_op(OP_POP, 32'h0, 2'd0);
        add_op(OP_POP, 32'h0, 2'd0);
        add_op(OP_POP, 32'h0, 2'd0);
        add_op(OP_POP, 32'h0, 2'd0);
        add_op(OP_POP, 32'h0, 2'd0);
        add_op(OP_UNUSED, 32'h0, 2'd0);
        add_random_ops(400);
        wait_drained();

        send_idle = 52;
        recv_idle = 20;
        add_random_ops(420);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        add_random_ops(420);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
